// ----- sv/record_deframe_xor_decrypt_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the record deframer
// Shared concurrent assertion shorthands, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef RECORD_DEFRAME_XOR_DECRYPT_CORE_ASSERT_SVH
`define RECORD_DEFRAME_XOR_DECRYPT_CORE_ASSERT_SVH

// same-cycle implication
`define RDXD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RDXD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/rdxd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdxd_pkg
// Types and constants shared by the record deframer modules.
// ----------------------------------------------------------------------------
package rdxd_pkg;

    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 32;
    localparam logic [3:0]  HDR_LAST   = 4'd9;
    localparam logic [3:0]  IN_PAYLOAD = 4'd10;
    localparam logic [3:0]  LEN_LO     = 4'd8;

    typedef enum logic [2:0] {
        REG_YEAR   = 3'd0,
        REG_MONTH  = 3'd1,
        REG_DAY    = 3'd2,
        REG_HOUR   = 3'd3,
        REG_MINUTE = 3'd4,
        REG_SECOND = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] key_one;
        logic [31:0] key_two;
    } t_keys;

endpackage

// ----- sv/rdxd_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdxd_regs
// APB register file for the date/time fields and the key derivation.
// ----------------------------------------------------------------------------
module rdxd_regs
    import rdxd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_keys             o_keys
);

    logic [15:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    t_reg_idx    w_idx;
    logic        w_wr;
    logic [31:0] w_date;
    logic [31:0] w_time;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_YEAR:   r_year   <= pwdata[15:0];
                REG_MONTH:  r_month  <= pwdata[3:0];
                REG_DAY:    r_day    <= pwdata[4:0];
                REG_HOUR:   r_hour   <= pwdata[4:0];
                REG_MINUTE: r_minute <= pwdata[5:0];
                REG_SECOND: r_second <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_YEAR:   prdata = {16'd0, r_year};
            REG_MONTH:  prdata = {28'd0, r_month};
            REG_DAY:    prdata = {27'd0, r_day};
            REG_HOUR:   prdata = {27'd0, r_hour};
            REG_MINUTE: prdata = {26'd0, r_minute};
            REG_SECOND: prdata = {26'd0, r_second};
            default:    prdata = '0;
        endcase
    end

    // pack fields at their key positions, then shift right
    assign w_date = {3'd0, r_day, 4'd0, r_month, r_year};
    assign w_time = {2'd0, r_second, 2'd0, r_minute, 3'd0, r_hour, 8'd0};

    assign o_keys.key_one = {5'd0, w_date[31:5]};
    assign o_keys.key_two = {3'd0, w_time[31:3]};

endmodule

// ----- sv/record_deframe_xor_decrypt_core.sv -----
`timescale 1ns / 1ps
// Record deframer with XOR keystream decryption.
// Results are registered: each appears the cycle after its causing item is accepted.
// Throughput: 1 item per cycle unless stalled; output is refilled in the cycle it drains.
// The key seed multiply runs once per record, at the last header byte.
// Reset (synchronous, active low) clears all but output data; first byte is an id byte.
// ----------------------------------------------------------------------------
// record_deframe_xor_decrypt_core
// Parses length-prefixed records and decrypts whole payload words.
// ----------------------------------------------------------------------------
module record_deframe_xor_decrypt_core
    import rdxd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_stream_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_plain_byte,
    output logic [31:0]       o_record_id,
    output logic [31:0]       o_record_time,
    output logic [15:0]       o_record_length,
    output logic [15:0]       o_byte_offset,
    output logic              o_last_of_record,
    output logic              o_empty_record,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_keys       w_keys;

    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_id, n_id;
    logic [31:0] r_time, n_time;
    logic [15:0] r_length, n_length;
    logic [15:0] r_offset, n_offset;
    logic [31:0] r_key_two, n_key_two;
    logic [31:0] r_ks, n_ks;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_plain, n_plain;
    logic [15:0] r_out_len, n_out_len;
    logic [15:0] r_out_off, n_out_off;
    logic        r_out_last, n_out_last;
    logic        r_out_empty, n_out_empty;
    logic [31:0] r_out_id, n_out_id;
    logic [31:0] r_out_time, n_out_time;

    logic        w_accept;
    logic [31:0] w_seed;
    logic [31:0] w_key_one_inc;
    logic [7:0]  w_ks_byte;
    logic [16:0] w_off_next;
    logic        w_enc;
    logic        w_last;

    rdxd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_keys  (w_keys)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_key_one_inc = w_keys.key_one + 32'd1;
    assign w_seed        = w_key_one_inc * w_keys.key_two;

    always_comb begin
        case (r_offset[1:0])
            2'd0:    w_ks_byte = r_ks[7:0];
            2'd1:    w_ks_byte = r_ks[15:8];
            2'd2:    w_ks_byte = r_ks[23:16];
            default: w_ks_byte = r_ks[31:24];
        endcase
    end

    assign w_off_next = {1'b0, r_offset} + 17'd1;
    assign w_enc      = r_offset < {r_length[15:2], 2'b00};
    assign w_last     = w_off_next >= {1'b0, r_length};

    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_id        = r_id;
        n_time      = r_time;
        n_length    = r_length;
        n_offset    = r_offset;
        n_key_two   = r_key_two;
        n_ks        = r_ks;
        n_out_valid = r_out_valid && !i_out_ready;
        n_plain     = r_plain;
        n_out_id    = r_out_id;
        n_out_time  = r_out_time;
        n_out_len   = r_out_len;
        n_out_off   = r_out_off;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;

        if (w_accept) begin
            if (r_hdr_cnt != IN_PAYLOAD) begin
                // assemble header fields, little-endian
                case (r_hdr_cnt)
                    4'd0: n_id[7:0]       = i_stream_byte;
                    4'd1: n_id[15:8]      = i_stream_byte;
                    4'd2: n_id[23:16]     = i_stream_byte;
                    4'd3: n_id[31:24]     = i_stream_byte;
                    4'd4: n_time[7:0]     = i_stream_byte;
                    4'd5: n_time[15:8]    = i_stream_byte;
                    4'd6: n_time[23:16]   = i_stream_byte;
                    4'd7: n_time[31:24]   = i_stream_byte;
                    4'd8: n_length[7:0]   = i_stream_byte;
                    default: n_length[15:8] = i_stream_byte;
                endcase
                n_hdr_cnt = r_hdr_cnt + 4'd1;
                if (r_hdr_cnt == HDR_LAST) begin
                    // latch keys for this record
                    n_key_two = w_keys.key_two;
                    n_ks      = w_seed;
                    n_offset  = '0;
                    if (n_length == 16'd0) begin
                        n_hdr_cnt   = '0;
                        n_out_valid = 1'b1;
                        n_plain     = '0;
                        n_out_id    = n_id;
                        n_out_time  = n_time;
                        n_out_len   = '0;
                        n_out_off   = '0;
                        n_out_last  = 1'b1;
                        n_out_empty = 1'b1;
                    end else begin
                        n_hdr_cnt = IN_PAYLOAD;
                    end
                end
            end else begin
                n_out_valid = 1'b1;
                n_plain     = w_enc ? (i_stream_byte ^ w_ks_byte) : i_stream_byte;
                n_out_id    = r_id;
                n_out_time  = r_time;
                n_out_len   = r_length;
                n_out_off   = r_offset;
                n_out_last  = w_last;
                n_out_empty = 1'b0;
                // advance keystream after the top byte of a whole word
                if (w_enc && (r_offset[1:0] == 2'd3)) begin
                    n_ks = r_ks + r_key_two;
                end
                if (w_last) begin
                    n_hdr_cnt = '0;
                    n_offset  = '0;
                end else begin
                    n_offset = w_off_next[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt   <= '0;
            r_id        <= '0;
            r_time      <= '0;
            r_length    <= '0;
            r_offset    <= '0;
            r_key_two   <= '0;
            r_ks        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hdr_cnt   <= n_hdr_cnt;
            r_id        <= n_id;
            r_time      <= n_time;
            r_length    <= n_length;
            r_offset    <= n_offset;
            r_key_two   <= n_key_two;
            r_ks        <= n_ks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plain     <= n_plain;
        r_out_id    <= n_out_id;
        r_out_time  <= n_out_time;
        r_out_len   <= n_out_len;
        r_out_off   <= n_out_off;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
    end

    assign o_out_valid      = r_out_valid;
    assign o_plain_byte     = r_plain;
    assign o_record_id      = r_out_id;
    assign o_record_time    = r_out_time;
    assign o_record_length  = r_out_len;
    assign o_byte_offset    = r_out_off;
    assign o_last_of_record = r_out_last;
    assign o_empty_record   = r_out_empty;

endmodule

// ----- sv/rdxd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdxd_checker
// Port-level checks on the record deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "record_deframe_xor_decrypt_core_assert.svh"

module rdxd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [7:0]        o_plain_byte,
    input logic [15:0]       o_record_length,
    input logic [15:0]       o_byte_offset,
    input logic              o_last_of_record,
    input logic              o_empty_record
);

    // a stalled item holds its byte
    `RDXD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_plain_byte))

    // an empty output register always takes the next item
    `RDXD_ASSERT_NOW(a_ready_when_free, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // an empty record is a single zero item that closes the record
    `RDXD_ASSERT_NOW(a_empty_shape, i_clk, i_rst_n, o_out_valid && o_empty_record, o_last_of_record && (o_plain_byte == 8'd0) && (o_byte_offset == 16'd0) && (o_record_length == 16'd0))

    // payload offsets stay inside the stated length
    `RDXD_ASSERT_NOW(a_offset_range, i_clk, i_rst_n, o_out_valid && !o_empty_record, o_byte_offset < o_record_length)

    // the closing byte sits at the last position
    `RDXD_ASSERT_NOW(a_last_pos, i_clk, i_rst_n, o_out_valid && !o_empty_record && o_last_of_record, o_byte_offset == (o_record_length - 16'd1))

endmodule

bind record_deframe_xor_decrypt_core rdxd_checker u_rdxd_checker (.*);
